// File: rtl/cec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cec_pkg
// shared types, register codes and defaults of the correlation echo canceller
// ----------------------------------------------------------------------------
package cec_pkg;

  // default geometry
  localparam int HIST_DEPTH_DEF = 256;
  localparam int COEF_FRAC_DEF  = 24;

  // fixed datapath widths
  localparam int SMP_W = 16;
  localparam int CFG_W = 16;
  localparam int ACC_W = 64;
  localparam int QUO_W = 32;

  // register reset values
  localparam logic [7:0]  TAP_ORDER_RST  = 8'd31;
  localparam logic [7:0]  WINDOW_LEN_RST = 8'd64;
  localparam logic [15:0] ADAPT_DIV_RST  = 16'd16;

  typedef enum logic [1:0] {
    CFG_TAP_ORDER  = 2'd0,
    CFG_WINDOW_LEN = 2'd1,
    CFG_ADAPT_DIV  = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIR_RUN,
    S_FIR_WAIT,
    S_FIR_DONE,
    S_COR_RUN,
    S_COR_WAIT,
    S_DEN,
    S_DIV_START,
    S_DIV_WAIT,
    S_UPDATE
  } cec_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

// File: rtl/cec_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cec_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/cec_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cec_div
// restoring divider: min(mag * 2^FRAC / den, 2^31), one quotient bit a cycle
// ----------------------------------------------------------------------------
module cec_div
  import cec_pkg::*;
#(
  parameter int FRAC  = COEF_FRAC_DEF,
  parameter int DEN_W = 55
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [ACC_W-1:0] mag,
  input  wire logic [DEN_W-1:0] den,
  output div_status_t           status,
  output logic      [QUO_W-1:0] quotient
);

  localparam int SH   = QUO_W - FRAC;
  localparam int NH_W = ACC_W - SH;
  localparam int CMW  = (NH_W > DEN_W) ? NH_W : DEN_W;
  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [QUO_W-1:0] CAP = {1'b1, {(QUO_W-1){1'b0}}};

  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] lo;
  logic [QUO_W-1:0] q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [NH_W-1:0]  num_hi;
  logic             ovf;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;

  assign num_hi    = mag[ACC_W-1:SH];
  assign ovf       = CMW'(num_hi) >= CMW'(den);
  assign trial     = {rem, lo[QUO_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign fits      = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_q <= den;
        if (ovf) begin
          q    <= CAP;
          done <= 1'b1;
        end else begin
          rem  <= DEN_W'(num_hi);
          lo   <= {mag[SH-1:0], {FRAC{1'b0}}};
          q    <= '0;
          cnt  <= CNT_W'(QUO_W - 1);
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (fits) begin
          rem <= trial_sub[DEN_W-1:0];
          q   <= {q[QUO_W-2:0], 1'b1};
        end else begin
          rem <= trial[DEN_W-1:0];
          q   <= {q[QUO_W-2:0], 1'b0};
        end
        lo  <= {lo[QUO_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // step magnitude never exceeds 2^31
  assign quotient    = (q > CAP) ? CAP : q;
  assign status.busy = busy;
  assign status.done = done;

endmodule
`default_nettype wire

// File: rtl/correlation_echo_canceller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// correlation_echo_canceller
// adaptive echo canceller with correlation-normalized tap update
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one far-end and one echo
//   sample per request; output channel (out_valid / out_stall) returns one
//   residual per request. configuration is a plain write port (cfg_write,
//   cfg_index, cfg_data) and may be written any time the block is idle.
// sequence:
//   the block recomputes all service residuals, lags 0 to L; the residual
//   enters the output register when the lag-zero fir pass is done. it then
//   adapts taps 0 to M one by one from the correlation and energy over
//   lags 0 to N, with M the clamped tap order, L = depth - 1 - M and N the
//   clamped window; the single mac pipeline over the history ram and the
//   bit-serial divider do this work in turn, and no new request is taken
//   before the last tap is adapted.
// reset:
//   rst is synchronous; afterwards a clearing pass over all HIST_DEPTH
//   addresses zeroes the history and coefficient rams with in_stall held high.
// stall:
//   a stalled residual stays in the output register; processing of the next
//   request continues and waits only when its own residual is ready.
// ----------------------------------------------------------------------------
module correlation_echo_canceller
  import cec_pkg::*;
#(
  parameter int HIST_DEPTH     = HIST_DEPTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // input channel
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [SMP_W-1:0] far_sample,
  input  wire logic signed [SMP_W-1:0] echo_sample,
  // output channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed      [SMP_W-1:0] residual_sample,
  // configuration
  input  wire logic                    cfg_write,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data
);

  localparam int AW    = $clog2(HIST_DEPTH);
  localparam int CW    = (AW > 8) ? AW : 8;
  localparam int EN_W  = 31 + AW;          // energy sum of squares
  localparam int DEN_W = EN_W + 16;        // (energy + 1) * divisor
  localparam int PA_W  = SMP_W + 32;       // sample times coefficient
  localparam int F     = COEF_FRAC_BITS;

  localparam logic [AW-1:0] LAST_ADDR = AW'(HIST_DEPTH - 1);
  localparam logic [AW-1:0] M_MAX     = AW'(HIST_DEPTH - 2);
  localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(HIST_DEPTH);

  localparam logic signed [ACC_W-1:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] S32_MIN = -64'sd2147483648;
  localparam logic signed [ACC_W-1:0] S16_MAX = 64'sd32767;
  localparam logic signed [ACC_W-1:0] S16_MIN = -64'sd32768;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  tap_order;
  logic [7:0]  window_len;
  logic [15:0] adapt_divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_order     <= TAP_ORDER_RST;
      window_len    <= WINDOW_LEN_RST;
      adapt_divisor <= ADAPT_DIV_RST;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TAP_ORDER:  tap_order     <= cfg_data[7:0];
        CFG_WINDOW_LEN: window_len    <= cfg_data[7:0];
        CFG_ADAPT_DIV:  adapt_divisor <= cfg_data[15:0];
        default: ;  // index beyond the register list is ignored
      endcase
    end
  end

  // clamped geometry for the next request
  logic [AW-1:0] m_sel;
  logic [AW-1:0] last_sel;
  logic [AW-1:0] nw_sel;
  logic [15:0]   div_sel;

  assign m_sel    = (CW'(tap_order) > CW'(HIST_DEPTH - 2)) ? M_MAX : AW'(tap_order);
  assign last_sel = LAST_ADDR - m_sel;
  assign nw_sel   = (CW'(window_len) < CW'(last_sel)) ? AW'(window_len) : last_sel;
  assign div_sel  = (adapt_divisor == 16'd0) ? 16'd1 : adapt_divisor;

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  cec_state_t  state;
  cec_state_t  state_next;
  div_status_t div_st;

  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] wp;          // newest history entry
  logic [AW-1:0] wp_next;
  logic [AW-1:0] i_cnt;       // tap index
  logic [AW-1:0] j_cnt;       // lag index
  logic [AW-1:0] m_q;
  logic [AW-1:0] last_q;
  logic [AW-1:0] nw_q;
  logic [15:0]   div_q;
  logic          p1_valid;    // ram data valid
  logic          p2_valid;    // product valid

  logic accept;
  logic issue;
  logic fin_go;
  logic div_start;
  logic clearing;
  logic fir_phase;
  logic acc_clr;

  assign clearing  = (state == S_CLEAR);
  assign fir_phase = (state == S_FIR_RUN) || (state == S_FIR_WAIT);
  assign in_stall  = (state != S_IDLE);
  assign wp_next   = (wp == LAST_ADDR) ? '0 : wp + 1'b1;
  assign acc_clr   = accept || fin_go || (state == S_UPDATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    issue      = 1'b0;
    fin_go     = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == LAST_ADDR) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          accept     = 1'b1;
          state_next = S_FIR_RUN;
        end
      end
      S_FIR_RUN: begin
        issue = 1'b1;
        if (i_cnt == m_q) state_next = S_FIR_WAIT;
      end
      S_FIR_WAIT: begin
        if (!p1_valid && !p2_valid) state_next = S_FIR_DONE;
      end
      S_FIR_DONE: begin
        // lag zero also loads the output register, so it waits for room
        if ((j_cnt != '0) || !out_valid || !out_stall) begin
          fin_go     = 1'b1;
          state_next = (j_cnt == last_q) ? S_COR_RUN : S_FIR_RUN;
        end
      end
      S_COR_RUN: begin
        issue = 1'b1;
        if (j_cnt == nw_q) state_next = S_COR_WAIT;
      end
      S_COR_WAIT: begin
        if (!p1_valid && !p2_valid) state_next = S_DEN;
      end
      S_DEN: begin
        state_next = S_DIV_START;
      end
      S_DIV_START: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_st.done) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        state_next = (i_cnt == m_q) ? S_IDLE : S_COR_RUN;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // history addressing: entry k back from the newest sample
  // --------------------------------------------------------------------------
  function automatic logic [AW-1:0] hist_addr(input logic [AW-1:0] base,
                                              input logic [AW:0]   back);
    logic [AW:0] b;
    logic [AW:0] a;
    b = {1'b0, base};
    if (b >= back) a = b - back;
    else           a = b + DEPTH_X - back;
    return a[AW-1:0];
  endfunction

  logic [AW:0]   k_sum;
  logic [AW-1:0] far_raddr;
  logic [AW-1:0] echo_raddr;

  assign k_sum      = {1'b0, i_cnt} + {1'b0, j_cnt};
  assign far_raddr  = hist_addr(wp, k_sum);
  assign echo_raddr = hist_addr(wp, {1'b0, j_cnt});

  // --------------------------------------------------------------------------
  // state memories
  // --------------------------------------------------------------------------
  logic                    hist_we;
  logic [AW-1:0]           hist_waddr;
  logic signed [SMP_W-1:0] far_wdata;
  logic signed [SMP_W-1:0] echo_wdata;
  logic signed [SMP_W-1:0] far_rdata;
  logic signed [SMP_W-1:0] echo_rdata;

  logic                    coef_we;
  logic [AW-1:0]           coef_waddr;
  logic signed [31:0]      coef_wdata;
  logic signed [31:0]      coef_rdata;
  logic signed [31:0]      coef_new;

  logic                    serv_we;
  logic signed [31:0]      serv_wdata;
  logic signed [31:0]      serv_rdata;

  assign hist_we    = clearing || accept;
  assign hist_waddr = clearing ? clr_cnt : wp_next;
  assign far_wdata  = clearing ? '0 : far_sample;
  assign echo_wdata = clearing ? '0 : echo_sample;

  assign coef_we    = clearing || (state == S_UPDATE);
  assign coef_waddr = clearing ? clr_cnt : i_cnt;
  assign coef_wdata = clearing ? '0 : coef_new;

  assign serv_we    = fin_go;

  cec_ram #(.WIDTH(SMP_W), .DEPTH(HIST_DEPTH)) u_far_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (far_wdata),
    .raddr (far_raddr),
    .rdata (far_rdata)
  );

  cec_ram #(.WIDTH(SMP_W), .DEPTH(HIST_DEPTH)) u_echo_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (echo_wdata),
    .raddr (echo_raddr),
    .rdata (echo_rdata)
  );

  cec_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (i_cnt),
    .rdata (coef_rdata)
  );

  // service residuals are always rewritten before they are read
  cec_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_serv_ram (
    .clk   (clk),
    .we    (serv_we),
    .waddr (j_cnt),
    .wdata (serv_wdata),
    .raddr (j_cnt),
    .rdata (serv_rdata)
  );

  // --------------------------------------------------------------------------
  // mac pipeline: ram read, product register, accumulate
  // --------------------------------------------------------------------------
  logic signed [31:0]      mult_sel;
  logic signed [PA_W-1:0]  prod_a;
  logic        [31:0]      prod_b;
  logic signed [31:0]      sq;
  logic signed [ACC_W-1:0] acc_a;    // fir sum, then correlation
  logic        [EN_W-1:0]  acc_e;    // window energy
  logic        [DEN_W-1:0] den;
  logic        [DEN_W-1:0] den_prod;

  assign mult_sel = fir_phase ? coef_rdata : serv_rdata;
  assign sq       = far_rdata * far_rdata;
  assign den_prod = DEN_W'(acc_e + EN_W'(1)) * DEN_W'(div_q);

  always_ff @(posedge clk) begin
    if (p1_valid) begin
      prod_a <= far_rdata * mult_sel;
      prod_b <= sq;
    end
    if (acc_clr) begin
      acc_a <= '0;
      acc_e <= '0;
    end else if (p2_valid) begin
      acc_a <= acc_a + {{(ACC_W-PA_W){prod_a[PA_W-1]}}, prod_a};
      acc_e <= acc_e + EN_W'(prod_b);
    end
    if (state == S_DEN) begin
      den <= den_prod;
    end
  end

  // --------------------------------------------------------------------------
  // residual at the current lag, truncated toward zero
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] echo_scaled;
  logic signed [ACC_W-1:0] diff;
  logic        [ACC_W-1:0] diff_mag;
  logic        [ACC_W-1:0] diff_shr;
  logic signed [ACC_W-1:0] res;
  logic signed [SMP_W-1:0] res16;

  assign echo_scaled = {{(ACC_W-SMP_W){echo_rdata[SMP_W-1]}}, echo_rdata} <<< F;
  assign diff        = echo_scaled - acc_a;
  assign diff_mag    = diff[ACC_W-1] ? (~diff + 1'b1) : diff;
  assign diff_shr    = diff_mag >> F;
  assign res         = diff[ACC_W-1] ? $signed(~diff_shr + 1'b1) : $signed(diff_shr);

  always_comb begin
    if (res > S32_MAX)      serv_wdata = 32'sh7FFF_FFFF;
    else if (res < S32_MIN) serv_wdata = 32'sh8000_0000;
    else                    serv_wdata = res[31:0];
    if (res > S16_MAX)      res16 = 16'sh7FFF;
    else if (res < S16_MIN) res16 = 16'sh8000;
    else                    res16 = res[SMP_W-1:0];
  end

  // --------------------------------------------------------------------------
  // tap update: coef + step, step = corr * 2^F / den
  // --------------------------------------------------------------------------
  logic [ACC_W-1:0]   corr_mag;
  logic [QUO_W-1:0]   step_mag;
  logic signed [32:0] step_s;
  logic signed [31:0] step_sat;
  logic signed [33:0] coef_sum;

  assign corr_mag = acc_a[ACC_W-1] ? (~acc_a + 1'b1) : acc_a;

  cec_div #(.FRAC(F), .DEN_W(DEN_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .mag      (corr_mag),
    .den      (den),
    .status   (div_st),
    .quotient (step_mag)
  );

  always_comb begin
    step_s = acc_a[ACC_W-1] ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
    if (step_s > 33'sh0_7FFF_FFFF) step_sat = 32'sh7FFF_FFFF;
    else                           step_sat = step_s[31:0];
    coef_sum = {{2{coef_rdata[31]}}, coef_rdata} + {{2{step_sat[31]}}, step_sat};
    if (coef_sum > 34'sh0_7FFF_FFFF)       coef_new = 32'sh7FFF_FFFF;
    else if (coef_sum < -34'sh0_8000_0000) coef_new = 32'sh8000_0000;
    else                                   coef_new = coef_sum[31:0];
  end

  // --------------------------------------------------------------------------
  // counters, pipeline valids and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      wp        <= '0;
      i_cnt     <= '0;
      j_cnt     <= '0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
      p2_valid <= p1_valid;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (accept) begin
        wp     <= wp_next;
        m_q    <= m_sel;
        last_q <= last_sel;
        nw_q   <= nw_sel;
        div_q  <= div_sel;
        i_cnt  <= '0;
        j_cnt  <= '0;
      end
      if ((state == S_FIR_RUN) && (i_cnt != m_q)) begin
        i_cnt <= i_cnt + 1'b1;
      end
      if (fin_go) begin
        i_cnt <= '0;
        j_cnt <= (j_cnt == last_q) ? '0 : j_cnt + 1'b1;
      end
      if ((state == S_COR_RUN) && (j_cnt != nw_q)) begin
        j_cnt <= j_cnt + 1'b1;
      end
      if (state == S_UPDATE) begin
        i_cnt <= i_cnt + 1'b1;
        j_cnt <= '0;
      end
      // newest residual goes out, a taken one frees the register
      if (fin_go && (j_cnt == '0)) begin
        out_valid       <= 1'b1;
        residual_sample <= res16;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_drained_at_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIR_DONE) |-> (!p1_valid && !p2_valid))
    else $error("fir residual taken before the mac pipeline drained");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (!p1_valid && !p2_valid && !div_st.busy))
    else $error("request taken while work is in flight");

  a_tap_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIR_RUN) || (state == S_UPDATE)) |-> (i_cnt <= m_q))
    else $error("tap index beyond tap order");

endmodule
`default_nettype wire
